@@ rtl/cdb_pkg.sv @@
package cdb_pkg;

  localparam int MAXP  = 8;
  localparam int VC_W  = 16;
  localparam int SEQ_W = 32;
  localparam int SRC_W = 4;

  typedef logic [VC_W-1:0] vc_t;

  typedef enum logic [1:0] {
    KIND_DELIV = 2'd0,
    KIND_NONE  = 2'd1,
    KIND_ERR   = 2'd2,
    KIND_STAMP = 2'd3
  } kind_t;

  localparam logic CFG_OWN_ID = 1'b0;
  localparam logic CFG_MASK   = 1'b1;

  // status that one sender lane reports to the merge sequencer
  typedef struct packed {
    logic ready;
    logic dup;
    logic full;
  } lane_stat_t;

endpackage

@@ rtl/cdb_lane.sv @@
module cdb_lane #(
  parameter int NUM_PROCS  = 8,
  parameter int PEND_DEPTH = 8,
  parameter int CMP_W      = 16,
  parameter int LANE_ID    = 0
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic [NUM_PROCS-1:0][cdb_pkg::VC_W-1:0]  key,
  input  logic [cdb_pkg::SEQ_W-1:0]                key_seq,
  input  logic                                     ins,
  input  logic                                     pop,
  input  logic [NUM_PROCS-1:0][CMP_W-1:0]          local_clk,
  output cdb_pkg::lane_stat_t                      stat,
  output logic [cdb_pkg::SEQ_W-1:0]                head_seq
);
  import cdb_pkg::*;

  localparam int FW = $clog2(PEND_DEPTH + 1);

  logic [PEND_DEPTH-1:0][NUM_PROCS-1:0][VC_W-1:0] clk_r, clk_nxt, sh_clk;
  logic [PEND_DEPTH-1:0][SEQ_W-1:0]               seq_r, seq_nxt, sh_seq;
  logic [FW-1:0]                                  fill_r, fill_nxt;
  logic [PEND_DEPTH-1:0]                          vld, lt, eq, prev_lt;
  logic                                           all_le;

  // compare every entry's own-sender slot with the new key
  always_comb begin
    for (int i = 0; i < PEND_DEPTH; i++) begin
      vld[i] = FW'(i) < fill_r;
      lt[i]  = vld[i] && (clk_r[i][LANE_ID] < key[LANE_ID]);
      eq[i]  = vld[i] && (clk_r[i][LANE_ID] == key[LANE_ID]);
    end
    prev_lt[0] = 1'b1;
    sh_clk[0]  = key;
    sh_seq[0]  = key_seq;
    for (int i = 1; i < PEND_DEPTH; i++) begin
      prev_lt[i] = lt[i-1];
      sh_clk[i]  = clk_r[i-1];
      sh_seq[i]  = seq_r[i-1];
    end
  end

  // check head against local clock
  always_comb begin
    all_le = 1'b1;
    for (int j = 0; j < NUM_PROCS; j++) begin
      if (CMP_W'(clk_r[0][j]) > local_clk[j]) all_le = 1'b0;
    end
  end

  assign stat.ready = (fill_r != '0) && all_le;
  assign stat.dup   = |eq;
  assign stat.full  = fill_r == FW'(PEND_DEPTH);
  assign head_seq   = seq_r[0];

  // insert in sorted place or pop the head
  always_comb begin
    clk_nxt  = clk_r;
    seq_nxt  = seq_r;
    fill_nxt = fill_r;
    if (ins) begin
      for (int i = 0; i < PEND_DEPTH; i++) begin
        if (!lt[i] && prev_lt[i]) begin
          clk_nxt[i] = key;
          seq_nxt[i] = key_seq;
        end else if (!lt[i]) begin
          clk_nxt[i] = sh_clk[i];
          seq_nxt[i] = sh_seq[i];
        end
      end
      fill_nxt = fill_r + 1'b1;
    end else if (pop) begin
      for (int i = 0; i < PEND_DEPTH - 1; i++) begin
        clk_nxt[i] = clk_r[i+1];
        seq_nxt[i] = seq_r[i+1];
      end
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    clk_r <= clk_nxt;
    seq_r <= seq_nxt;
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

@@ rtl/causal_delivery_buffer.sv @@
// Broadcast: stamp strobed in the cycle after start; busy stays low, one per cycle.
// Receive: a check state, then scan passes over the sender lanes, delivering each ready head;
// the scan ends on a pass without delivery, an insert error ends after the check.
// Each delivery is held until the next one is found or the scan ends; the final
// result is strobed in the first cycle with busy low.
// Sync active-low reset clears clocks, counts, fills, mask and state, sets own ID to 1; receiver never stalls.
module causal_delivery_buffer #(
  parameter int NUM_PROCS  = 8,
  parameter int PEND_DEPTH = 8,
  parameter int CLOCK_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [cdb_pkg::SRC_W-1:0]   in_src,
  input  logic [cdb_pkg::SEQ_W-1:0]   in_seq_nr,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc0,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc1,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc2,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc3,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc4,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc5,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc6,
  input  logic [cdb_pkg::VC_W-1:0]    in_vc7,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [7:0]                  cfg_data,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [cdb_pkg::SRC_W-1:0]   out_src,
  output logic [cdb_pkg::SEQ_W-1:0]   out_seq,
  output logic [cdb_pkg::VC_W-1:0]    out_st0,
  output logic [cdb_pkg::VC_W-1:0]    out_st1,
  output logic [cdb_pkg::VC_W-1:0]    out_st2,
  output logic [cdb_pkg::VC_W-1:0]    out_st3,
  output logic [cdb_pkg::VC_W-1:0]    out_st4,
  output logic [cdb_pkg::VC_W-1:0]    out_st5,
  output logic [cdb_pkg::VC_W-1:0]    out_st6,
  output logic [cdb_pkg::VC_W-1:0]    out_st7,
  output logic                        out_last
);
  import cdb_pkg::*;

  localparam int CMP_W = (CLOCK_BITS > VC_W) ? CLOCK_BITS : VC_W;
  localparam int PW    = $clog2(NUM_PROCS);
  localparam logic [CLOCK_BITS-1:0] CLK_MAX = {CLOCK_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SCAN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [3:0]                             own_id_r;
  logic [NUM_PROCS-1:0]                   mask_r;
  logic [NUM_PROCS-1:0][CLOCK_BITS-1:0]   lc_r;
  logic [CLOCK_BITS-1:0]                  bcnt_r;
  logic [NUM_PROCS-1:0][CMP_W-1:0]        lc_ext;

  logic [MAXP-1:0][VC_W-1:0]              vc_in;
  logic [NUM_PROCS-1:0][VC_W-1:0]         key_r;
  logic [SEQ_W-1:0]                       kseq_r;
  logic [SRC_W-1:0]                       ksrc_r;

  logic [PW-1:0]                          p_r;
  logic                                   any_r;
  lane_stat_t [NUM_PROCS-1:0]             stat;
  logic [NUM_PROCS-1:0][SEQ_W-1:0]        hseq;
  logic [NUM_PROCS-1:0]                   ins, pop;

  logic                                   hold_r;
  logic [PW-1:0]                          hsrc_r;
  logic [SEQ_W-1:0]                       hseq_r;

  logic                                   ov_r, olast_r;
  kind_t                                  okind_r;
  logic [SRC_W-1:0]                       osrc_r;
  logic [SEQ_W-1:0]                       oseq_r;
  logic [MAXP-1:0][VC_W-1:0]              ost_r;

  logic                                   accept, src_ok, ins_err, deliver, pass_end;
  logic [PW-1:0]                          sidx;

  assign vc_in  = {in_vc7, in_vc6, in_vc5, in_vc4, in_vc3, in_vc2, in_vc1, in_vc0};
  assign accept = start && !busy;
  assign busy   = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  always_comb begin
    for (int j = 0; j < NUM_PROCS; j++) lc_ext[j] = CMP_W'(lc_r[j]);
  end

  // sender lanes
  for (genvar g = 0; g < NUM_PROCS; g++) begin : g_lane
    cdb_lane #(
      .NUM_PROCS (NUM_PROCS),
      .PEND_DEPTH(PEND_DEPTH),
      .CMP_W     (CMP_W),
      .LANE_ID   (g)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .key      (key_r),
      .key_seq  (kseq_r),
      .ins      (ins[g]),
      .pop      (pop[g]),
      .local_clk(lc_ext),
      .stat     (stat[g]),
      .head_seq (hseq[g])
    );
  end

  assign src_ok  = (ksrc_r != '0) && (ksrc_r <= SRC_W'(NUM_PROCS));
  assign sidx    = PW'(ksrc_r - 1'b1);
  assign ins_err = !src_ok || stat[sidx].full || stat[sidx].dup;
  assign deliver = (state_r == S_SCAN) && stat[p_r].ready;
  assign pass_end = (state_r == S_SCAN) && !stat[p_r].ready &&
                    (p_r == PW'(NUM_PROCS - 1)) && !any_r;

  always_comb begin
    for (int j = 0; j < NUM_PROCS; j++) begin
      ins[j] = (state_r == S_CHECK) && !ins_err && (sidx == PW'(j));
      pop[j] = deliver && (p_r == PW'(j));
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && !in_cmd) state_nxt = S_CHECK;
      S_CHECK: state_nxt = ins_err ? S_IDLE : S_SCAN;
      S_SCAN:  if (pass_end) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control, config and clock state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      own_id_r <= 4'd1;
      mask_r   <= '0;
      lc_r     <= '0;
      bcnt_r   <= '0;
      p_r      <= '0;
      any_r    <= 1'b0;
      hold_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_OWN_ID) own_id_r <= cfg_data[3:0];
        else                         mask_r   <= cfg_data[NUM_PROCS-1:0];
      end
      if (accept && in_cmd && bcnt_r != CLK_MAX) bcnt_r <= bcnt_r + 1'b1;
      ov_r <= 1'b0;
      if (accept && in_cmd) ov_r <= 1'b1;
      if (state_r == S_CHECK) begin
        p_r   <= '0;
        any_r <= 1'b0;
        if (ins_err) ov_r <= 1'b1;
      end
      if (state_r == S_SCAN) begin
        if (deliver) begin
          any_r  <= 1'b1;
          hold_r <= 1'b1;
          if (hold_r) ov_r <= 1'b1;
          if (lc_r[p_r] != CLK_MAX) lc_r[p_r] <= lc_r[p_r] + 1'b1;
        end else if (p_r == PW'(NUM_PROCS - 1)) begin
          p_r   <= '0;
          any_r <= 1'b0;
          if (!any_r) begin
            ov_r   <= 1'b1;
            hold_r <= 1'b0;
          end
        end else begin
          p_r <= p_r + 1'b1;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r  <= vc_in[NUM_PROCS-1:0];
      kseq_r <= in_seq_nr;
      ksrc_r <= in_src;
    end
    if (accept && in_cmd) begin
      okind_r <= KIND_STAMP;
      osrc_r  <= '0;
      oseq_r  <= in_seq_nr;
      olast_r <= 1'b1;
      ost_r   <= '0;
      for (int j = 0; j < NUM_PROCS; j++) begin
        if (own_id_r == SRC_W'(j + 1))
          ost_r[j] <= VC_W'(CMP_W'(bcnt_r));
        else if (mask_r[j])
          ost_r[j] <= VC_W'(lc_ext[j]);
      end
    end
    if (state_r == S_CHECK) begin
      okind_r <= KIND_ERR;
      osrc_r  <= '0;
      oseq_r  <= '0;
      olast_r <= 1'b1;
      ost_r   <= '0;
    end
    if (deliver) begin
      hsrc_r  <= p_r;
      hseq_r  <= hseq[p_r];
      okind_r <= KIND_DELIV;
      osrc_r  <= SRC_W'(hsrc_r) + 1'b1;
      oseq_r  <= hseq_r;
      olast_r <= 1'b0;
      ost_r   <= '0;
    end else if (pass_end) begin
      okind_r <= hold_r ? KIND_DELIV : KIND_NONE;
      osrc_r  <= hold_r ? SRC_W'(hsrc_r) + 1'b1 : '0;
      oseq_r  <= hold_r ? hseq_r : '0;
      olast_r <= 1'b1;
      ost_r   <= '0;
    end
  end

  assign out_valid = ov_r;
  assign out_kind  = okind_r;
  assign out_src   = osrc_r;
  assign out_seq   = oseq_r;
  assign out_last  = olast_r;
  assign out_st0   = ost_r[0];
  assign out_st1   = ost_r[1];
  assign out_st2   = ost_r[2];
  assign out_st3   = ost_r[3];
  assign out_st4   = ost_r[4];
  assign out_st5   = ost_r[5];
  assign out_st6   = ost_r[6];
  assign out_st7   = ost_r[7];

`ifndef SYNTHESIS
  a_bcast_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_cmd |=> out_valid && out_kind == KIND_STAMP && out_last)
    else $error("broadcast did not give a stamp");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_last && out_src == '0)
    else $error("insert error not final");
  a_deliv_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DELIV |-> out_src != '0)
    else $error("delivery without sender");
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> !busy)
    else $error("busy after final result");
`endif

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdb_pkg::*;

  localparam int NP = 8;
  localparam int DEPTH = 8;
  localparam logic [15:0] CMAX = 16'hFFFF;
  localparam int LIMIT = 2000000;
  localparam int EXPN = 256;
  localparam int MAX_ROWS = 32;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = 1'b0;
  logic [3:0] in_src = '0;
  logic [31:0] in_seq_nr = '0;
  logic [15:0] in_vc [NP];
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [7:0] cfg_data = '0;
  logic out_valid;
  logic [1:0] out_kind;
  logic [3:0] out_src;
  logic [31:0] out_seq;
  logic [15:0] out_st [NP];
  logic out_last;

  causal_delivery_buffer uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .in_src(in_src), .in_seq_nr(in_seq_nr),
    .in_vc0(in_vc[0]), .in_vc1(in_vc[1]), .in_vc2(in_vc[2]), .in_vc3(in_vc[3]),
    .in_vc4(in_vc[4]), .in_vc5(in_vc[5]), .in_vc6(in_vc[6]), .in_vc7(in_vc[7]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .out_valid(out_valid), .out_kind(out_kind),
    .out_src(out_src), .out_seq(out_seq),
    .out_st0(out_st[0]), .out_st1(out_st[1]), .out_st2(out_st[2]), .out_st3(out_st[3]),
    .out_st4(out_st[4]), .out_st5(out_st[5]), .out_st6(out_st[6]), .out_st7(out_st[7]),
    .out_last(out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  typedef struct {
    kind_t kind;
    logic [3:0] src;
    logic [31:0] seq;
    logic [15:0] st [NP];
    logic last;
  } delivery_t;

  typedef struct {
    logic cmd;
    logic [3:0] src;
    logic [31:0] seq;
    logic [15:0] vc [NP];
  } msg_t;

  typedef struct {
    msg_t m;
    bit typed;
    delivery_t e;
  } row_t;

  // predictor state
  logic [15:0] lclk [NP];
  logic [15:0] bcast_cnt;
  logic [15:0] pend_vc [NP][DEPTH][NP];
  logic [31:0] pend_seq [NP][DEPTH];
  int pend_fill [NP];
  logic [3:0] own_id;
  logic [7:0] aff_mask;

  // expected results, oldest at exp_rd
  delivery_t exp_mem [EXPN];
  int exp_wr = 0, exp_rd = 0;
  int errors = 0;
  int n_deliv = 0, n_stamp = 0, n_err = 0, n_none = 0, n_items = 0;
  int cycles = 0;

  row_t rows [MAX_ROWS];
  int n_rows = 0;

  function automatic logic [15:0] sat_inc(logic [15:0] v);
    return (v == CMAX) ? CMAX : v + 16'd1;
  endfunction

  function automatic void exp_put(delivery_t d);
    exp_mem[exp_wr % EXPN] = d;
    exp_wr++;
  endfunction

  function automatic void mark_last();
    exp_mem[(exp_wr - 1) % EXPN].last = 1'b1;
  endfunction

  function automatic void push_plain(kind_t k, logic [3:0] s, logic [31:0] q);
    delivery_t d;
    d.kind = k; d.src = s; d.seq = q; d.last = 1'b0;
    foreach (d.st[i]) d.st[i] = '0;
    exp_put(d);
  endfunction

  function automatic bit head_ready(int p);
    if (pend_fill[p] == 0) return 0;
    for (int i = 0; i < NP; i++)
      if (lclk[i] < pend_vc[p][0][i]) return 0;
    return 1;
  endfunction

  // compute the results one message causes and advance the predictor
  function automatic void predict_msg(msg_t m);
    delivery_t d;
    int p, pos, cnt;
    bit any;
    if (m.cmd) begin
      d.kind = KIND_STAMP; d.src = '0; d.seq = m.seq; d.last = 1'b1;
      for (int i = 0; i < NP; i++) d.st[i] = aff_mask[i] ? lclk[i] : 16'd0;
      if (own_id >= 1 && own_id <= NP) d.st[own_id-1] = bcast_cnt;
      bcast_cnt = sat_inc(bcast_cnt);
      exp_put(d);
      return;
    end
    if (m.src < 1 || m.src > NP || pend_fill[m.src-1] >= DEPTH) begin
      push_plain(KIND_ERR, '0, '0);
      mark_last();
      return;
    end
    p = m.src - 1;
    pos = pend_fill[p];
    for (int i = 0; i < pend_fill[p]; i++) begin
      if (pend_vc[p][i][p] == m.vc[p]) begin
        push_plain(KIND_ERR, '0, '0);
        mark_last();
        return;
      end
      if (m.vc[p] < pend_vc[p][i][p]) begin
        pos = i;
        break;
      end
    end
    for (int i = pend_fill[p]; i > pos; i--) begin
      pend_vc[p][i] = pend_vc[p][i-1];
      pend_seq[p][i] = pend_seq[p][i-1];
    end
    pend_vc[p][pos] = m.vc;
    pend_seq[p][pos] = m.seq;
    pend_fill[p]++;
    // rescan heads until a pass delivers nothing
    cnt = 0;
    do begin
      any = 0;
      for (int q = 0; q < NP; q++) begin
        while (head_ready(q) && cnt < NP * DEPTH) begin
          push_plain(KIND_DELIV, 4'(q + 1), pend_seq[q][0]);
          cnt++;
          for (int i = 0; i + 1 < pend_fill[q]; i++) begin
            pend_vc[q][i] = pend_vc[q][i+1];
            pend_seq[q][i] = pend_seq[q][i+1];
          end
          pend_fill[q]--;
          lclk[q] = sat_inc(lclk[q]);
          any = 1;
        end
      end
    end while (any);
    if (cnt == 0) push_plain(KIND_NONE, '0, '0);
    mark_last();
  endfunction

  // check every strobed result against the oldest expectation
  always @(posedge clk) begin
    delivery_t e;
    cycles++;
    if (rst_n && out_valid) begin
      if (exp_rd == exp_wr) begin
        $error("unexpected result kind=%0d src=%0d seq=%0h", out_kind, out_src, out_seq);
        errors++;
      end else begin
        e = exp_mem[exp_rd % EXPN];
        exp_rd++;
        case (e.kind)
          KIND_DELIV: n_deliv++;
          KIND_STAMP: n_stamp++;
          KIND_ERR: n_err++;
          default: n_none++;
        endcase
        if (out_kind !== e.kind) begin
          $error("kind expected %0d actual %0d", e.kind, out_kind); errors++;
        end
        if (out_src !== e.src) begin
          $error("out_src expected %0d actual %0d", e.src, out_src); errors++;
        end
        if (out_seq !== e.seq) begin
          $error("out_seq expected %0h actual %0h", e.seq, out_seq); errors++;
        end
        for (int i = 0; i < NP; i++)
          if (out_st[i] !== e.st[i]) begin
            $error("st%0d expected %0h actual %0h", i, e.st[i], out_st[i]); errors++;
          end
        if (out_last !== e.last) begin
          $error("last expected %0b actual %0b", e.last, out_last); errors++;
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("causal_delivery_buffer verification failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    return g;
  endfunction

  // drop start, wait for all results, then let the block settle before a register write
  task automatic drain();
    start <= 1'b0;
    while (exp_wr != exp_rd || busy) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_OWN_ID) own_id = val[3:0];
    else aff_mask = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // hold start until the transfer, then idle for a random gap
  task automatic send_msg(msg_t m, bit typed, delivery_t te);
    int g;
    in_cmd <= m.cmd;
    in_src <= m.src;
    in_seq_nr <= m.seq;
    for (int i = 0; i < NP; i++) in_vc[i] <= m.vc[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_msg(m);
    if (typed) exp_mem[(exp_wr - 1) % EXPN] = te;
    n_items++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  function automatic msg_t make_msg(logic cmd, logic [3:0] s, logic [31:0] q, logic [15:0] fill);
    msg_t m;
    m.cmd = cmd; m.src = s; m.seq = q;
    foreach (m.vc[i]) m.vc[i] = fill;
    return m;
  endfunction

  // single final result with no sender and no stamp
  function automatic delivery_t plain_res(kind_t k, logic [31:0] q);
    delivery_t d;
    d.kind = k; d.src = '0; d.seq = q; d.last = 1'b1;
    foreach (d.st[i]) d.st[i] = '0;
    return d;
  endfunction

  function automatic void add_row(msg_t m, bit typed, delivery_t e);
    rows[n_rows].m = m;
    rows[n_rows].typed = typed;
    rows[n_rows].e = e;
    n_rows++;
  endfunction

  // receive for sender p: own count past local clock and pending list plus ahead, others mostly at most local clock
  function automatic msg_t causal_msg(int p, int ahead);
    msg_t m;
    m.cmd = 1'b0; m.src = 4'(p + 1); m.seq = $urandom;
    for (int i = 0; i < NP; i++)
      m.vc[i] = ($urandom_range(0, 5) == 0) ? lclk[i] + 16'($urandom_range(0, 2))
                                            : 16'($urandom_range(0, lclk[i]));
    m.vc[p] = lclk[p] + 16'(1 + pend_fill[p] + ahead);
    return m;
  endfunction

  initial begin
    msg_t m;
    delivery_t no_exp;
    // predictor reset
    foreach (in_vc[i]) in_vc[i] = '0;
    foreach (lclk[i]) lclk[i] = '0;
    foreach (pend_fill[i]) pend_fill[i] = 0;
    foreach (pend_vc[a, b, c]) pend_vc[a][b][c] = '0;
    foreach (pend_seq[a, b]) pend_seq[a][b] = '0;
    bcast_cnt = '0; own_id = 4'd1; aff_mask = '0;
    no_exp = plain_res(KIND_NONE, '0);

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table: broadcast after reset, bad senders, extremes, full list, duplicate
    add_row(make_msg(1'b1, 4'd0, 32'hFFFF_FFFF, 16'hFFFF), 1'b1,
            plain_res(KIND_STAMP, 32'hFFFF_FFFF));
    add_row(make_msg(1'b0, 4'd0, 32'h1234_5678, 16'd0), 1'b1, plain_res(KIND_ERR, '0));
    add_row(make_msg(1'b0, 4'd9, 32'h0, 16'd0), 1'b1, plain_res(KIND_ERR, '0));
    add_row(make_msg(1'b0, 4'd15, 32'h0, 16'hFFFF), 1'b1, plain_res(KIND_ERR, '0));
    add_row(make_msg(1'b0, 4'd1, 32'hA5A5_0001, 16'd0), 1'b0, no_exp);
    add_row(make_msg(1'b0, 4'd8, 32'hFFFF_FFFF, 16'hFFFF), 1'b0, no_exp);
    add_row(make_msg(1'b0, 4'd8, 32'h0, 16'hFFFF), 1'b0, no_exp);
    for (int k = 0; k < 8; k++)
      add_row(make_msg(1'b0, 4'd3, 32'(k), 16'(100 + k)), 1'b0, no_exp);
    add_row(make_msg(1'b0, 4'd3, 32'h77, 16'd50), 1'b0, no_exp);
    add_row(make_msg(1'b1, 4'd2, 32'h0, 16'd0), 1'b0, no_exp);
    add_row(make_msg(1'b0, 4'd2, 32'h5, 16'd1), 1'b0, no_exp);
    add_row(make_msg(1'b1, 4'd0, 32'h8000_0000, 16'd0), 1'b0, no_exp);
    for (int k = 0; k < n_rows; k++) send_msg(rows[k].m, rows[k].typed, rows[k].e);
    drain();

    // several register settings, extremes included; random traffic, mostly causal
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(CFG_OWN_ID, 8'd8); write_reg(CFG_MASK, 8'hFF); end
        1: begin write_reg(CFG_OWN_ID, 8'd0); write_reg(CFG_MASK, 8'h00); end
        2: begin write_reg(CFG_OWN_ID, 8'd15); write_reg(CFG_MASK, 8'hA5); end
        3: begin write_reg(CFG_OWN_ID, 8'd1); write_reg(CFG_MASK, 8'h5A); end
        default: begin
          write_reg(CFG_OWN_ID, 8'($urandom_range(0, 15)));
          write_reg(CFG_MASK, 8'($urandom));
        end
      endcase
      for (int k = 0; k < 85; k++) begin
        case ($urandom_range(0, 9))
          0, 1: m = make_msg(1'b1, 4'($urandom), $urandom, 16'($urandom));
          2: begin
            m = make_msg(1'b0, 4'($urandom), $urandom, 16'd0);
            foreach (m.vc[i]) m.vc[i] = 16'($urandom);
          end
          3: m = causal_msg($urandom_range(0, NP - 1), $urandom_range(1, 3));
          default: m = causal_msg($urandom_range(0, NP - 1), 0);
        endcase
        if ($urandom_range(0, 1) == 1) foreach (m.vc[i]) m.vc[i][15] = 1'b0;
        send_msg(m, 1'b0, no_exp);
      end
      drain();
    end

    // report what the run exercised
    $display("run covered %0d items: %0d deliveries, %0d stamps, %0d errors, %0d idle scans",
             n_items, n_deliv, n_stamp, n_err, n_none);
    if (errors == 0)
      $display("causal_delivery_buffer verification clean");
    else
      $display("causal_delivery_buffer verification failed");
    $finish;
  end

endmodule
